/* hdl/joint_effort_soft_hard_limiter_core_defines.svh */
// ----------------------------------------------------------------------------
// joint effort limiter assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef JOINT_EFFORT_SOFT_HARD_LIMITER_CORE_DEFINES_SVH
`define JOINT_EFFORT_SOFT_HARD_LIMITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define JESHL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define JESHL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define JESHL_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define JESHL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hdl/jeshl_pkg.sv */
// ----------------------------------------------------------------------------
// joint effort limiter package
// shared fixed point types and register indexes
// ----------------------------------------------------------------------------
package jeshl_pkg;

    typedef logic signed [31:0] sfix_t;
    typedef logic [30:0]        ufix_t;
    typedef logic [32:0]        mag_t;
    typedef logic signed [32:0] sdiff_t;
    typedef logic [63:0]        prod_t;
    typedef logic [2:0]         cfg_idx_t;

    localparam int PROD_W = 64;
    localparam int FRAC_W = 16;

    localparam cfg_idx_t REG_HARD_POS_MIN = 3'd0;
    localparam cfg_idx_t REG_HARD_POS_MAX = 3'd1;
    localparam cfg_idx_t REG_SOFT_POS_MIN = 3'd2;
    localparam cfg_idx_t REG_SOFT_POS_MAX = 3'd3;
    localparam cfg_idx_t REG_POS_GAIN     = 3'd4;
    localparam cfg_idx_t REG_VEL_GAIN     = 3'd5;
    localparam cfg_idx_t REG_VEL_LIMIT    = 3'd6;
    localparam cfg_idx_t REG_EFFORT_LIMIT = 3'd7;

endpackage

/* hdl/joint_effort_soft_hard_limiter_core.sv */
// ----------------------------------------------------------------------------
// joint effort soft and hard limiter core
// clamps a commanded joint effort to soft-limit and hard-limit bounds
// ----------------------------------------------------------------------------
//  channel   | ports                                              | handshake
//  ----------+----------------------------------------------------+------------------
//  command   | joint_position, joint_velocity, command_effort     | start, busy
//  result    | soft_limited_effort, hard_limited_effort           | done (one cycle)
//  config    | cfg_data, cfg_index                                | cfg_write
//
//  one word accepted every cycle
//  latency set by the two pairs of multiply-and-saturate units and the differences around them
//  busy is always low: the pipeline never stalls and the receiver cannot stall
//  asynchronous active-low reset clears the valid bits and all configuration registers to zero
// ----------------------------------------------------------------------------
`include "joint_effort_soft_hard_limiter_core_defines.svh"

module joint_effort_soft_hard_limiter_core #(
    parameter bit POS_LIMIT_EN = 1'b1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  jeshl_pkg::sfix_t  joint_position,
    input  jeshl_pkg::sfix_t  joint_velocity,
    input  jeshl_pkg::sfix_t  command_effort,
    output logic              done,
    output jeshl_pkg::sfix_t  soft_limited_effort,
    output jeshl_pkg::sfix_t  hard_limited_effort,
    input  logic              cfg_write,
    input  jeshl_pkg::cfg_idx_t cfg_index,
    input  logic [31:0]       cfg_data
);
    import jeshl_pkg::*;

    localparam int PIPE_D = 6;

    sfix_t hard_pos_min_reg;
    sfix_t hard_pos_max_reg;
    sfix_t soft_pos_min_reg;
    sfix_t soft_pos_max_reg;
    ufix_t pos_gain_reg;
    ufix_t vel_gain_reg;
    ufix_t vel_limit_reg;
    ufix_t effort_limit_reg;

    logic  accept;
    logic  s1_valid_reg;
    logic  s4_valid_reg;
    logic  done_reg;

    mag_t  s1_lo_mag_reg;
    mag_t  s1_hi_mag_reg;
    logic  s1_lo_neg_reg;
    logic  s1_hi_neg_reg;
    mag_t  s4_lo_mag_reg;
    mag_t  s4_hi_mag_reg;
    logic  s4_lo_neg_reg;
    logic  s4_hi_neg_reg;

    sfix_t vel_pipe_reg [3];
    sfix_t cmd_pipe_reg [PIPE_D];
    logic  lo_zero_pipe_reg [PIPE_D];
    logic  hi_zero_pipe_reg [PIPE_D];

    sdiff_t d_soft_lo;
    sdiff_t d_soft_hi;
    logic   lo_zero_next;
    logic   hi_zero_next;

    logic  vb_valid;
    sfix_t vb_lo;
    sfix_t vb_hi;
    sfix_t vlo;
    sfix_t vhi;
    sdiff_t d_vel_lo;
    sdiff_t d_vel_hi;

    logic  eb_valid;
    sfix_t eb_lo;
    sfix_t eb_hi;
    logic  eb_lo_valid_unused;
    logic  vb_hi_valid_unused;

    sfix_t emax;
    sfix_t soft_next;
    sfix_t hard_next;
    sfix_t hard_lo;
    sfix_t hard_hi;
    sfix_t soft_reg;
    sfix_t hard_reg;

    function automatic mag_t abs_mag(input sdiff_t d);
        if (d[32])
        begin
            return mag_t'(-d);
        end
        return mag_t'(d);
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hard_pos_min_reg <= '0;
            hard_pos_max_reg <= '0;
            soft_pos_min_reg <= '0;
            soft_pos_max_reg <= '0;
            pos_gain_reg     <= '0;
            vel_gain_reg     <= '0;
            vel_limit_reg    <= '0;
            effort_limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HARD_POS_MIN: hard_pos_min_reg <= sfix_t'(cfg_data);
                REG_HARD_POS_MAX: hard_pos_max_reg <= sfix_t'(cfg_data);
                REG_SOFT_POS_MIN: soft_pos_min_reg <= sfix_t'(cfg_data);
                REG_SOFT_POS_MAX: soft_pos_max_reg <= sfix_t'(cfg_data);
                REG_POS_GAIN:     pos_gain_reg     <= cfg_data[30:0];
                REG_VEL_GAIN:     vel_gain_reg     <= cfg_data[30:0];
                REG_VEL_LIMIT:    vel_limit_reg    <= cfg_data[30:0];
                REG_EFFORT_LIMIT: effort_limit_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // stage 1: distance to soft limits, hard limit tests
    assign d_soft_lo = sdiff_t'(soft_pos_min_reg) - sdiff_t'(joint_position);
    assign d_soft_hi = sdiff_t'(soft_pos_max_reg) - sdiff_t'(joint_position);

    always_comb
    begin
        lo_zero_next = 1'b0;
        hi_zero_next = 1'b0;
        if (POS_LIMIT_EN)
        begin
            lo_zero_next = joint_position < hard_pos_min_reg;
            hi_zero_next = !lo_zero_next && (joint_position > hard_pos_max_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s4_valid_reg <= vb_valid;
            done_reg     <= eb_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_lo_mag_reg <= abs_mag(d_soft_lo);
            s1_hi_mag_reg <= abs_mag(d_soft_hi);
            s1_lo_neg_reg <= d_soft_lo[32];
            s1_hi_neg_reg <= d_soft_hi[32];
        end
        vel_pipe_reg[0]     <= joint_velocity;
        cmd_pipe_reg[0]     <= command_effort;
        lo_zero_pipe_reg[0] <= lo_zero_next;
        hi_zero_pipe_reg[0] <= hi_zero_next;
        for (int i = 1; i < 3; i++)
        begin
            vel_pipe_reg[i] <= vel_pipe_reg[i-1];
        end
        for (int i = 1; i < PIPE_D; i++)
        begin
            cmd_pipe_reg[i]     <= cmd_pipe_reg[i-1];
            lo_zero_pipe_reg[i] <= lo_zero_pipe_reg[i-1];
            hi_zero_pipe_reg[i] <= hi_zero_pipe_reg[i-1];
        end
    end

    // stages 2-3: velocity bounds
    jeshl_scale_clamp u_vel_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_neg    (s1_lo_neg_reg),
        .in_mag    (s1_lo_mag_reg),
        .gain      (pos_gain_reg),
        .limit     (vel_limit_reg),
        .out_valid (vb_valid),
        .bound     (vb_lo)
    );

    jeshl_scale_clamp u_vel_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_neg    (s1_hi_neg_reg),
        .in_mag    (s1_hi_mag_reg),
        .gain      (pos_gain_reg),
        .limit     (vel_limit_reg),
        .out_valid (vb_hi_valid_unused),
        .bound     (vb_hi)
    );

    // stage 4: velocity error against each bound
    always_comb
    begin
        if (POS_LIMIT_EN)
        begin
            vlo = vb_lo;
            vhi = vb_hi;
        end
        else
        begin
            vlo = -$signed({1'b0, vel_limit_reg});
            vhi = $signed({1'b0, vel_limit_reg});
        end
    end

    assign d_vel_lo = sdiff_t'(vlo) - sdiff_t'(vel_pipe_reg[2]);
    assign d_vel_hi = sdiff_t'(vhi) - sdiff_t'(vel_pipe_reg[2]);

    always_ff @(posedge clk)
    begin
        if (vb_valid)
        begin
            s4_lo_mag_reg <= abs_mag(d_vel_lo);
            s4_hi_mag_reg <= abs_mag(d_vel_hi);
            s4_lo_neg_reg <= d_vel_lo[32];
            s4_hi_neg_reg <= d_vel_hi[32];
        end
    end

    // stages 5-6: effort bounds
    jeshl_scale_clamp u_eff_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_neg    (s4_lo_neg_reg),
        .in_mag    (s4_lo_mag_reg),
        .gain      (vel_gain_reg),
        .limit     (effort_limit_reg),
        .out_valid (eb_lo_valid_unused),
        .bound     (eb_lo)
    );

    jeshl_scale_clamp u_eff_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_neg    (s4_hi_neg_reg),
        .in_mag    (s4_hi_mag_reg),
        .gain      (vel_gain_reg),
        .limit     (effort_limit_reg),
        .out_valid (eb_valid),
        .bound     (eb_hi)
    );

    // stage 7: clamp the command, lower bound first
    assign emax = $signed({1'b0, effort_limit_reg});

    always_comb
    begin
        soft_next = cmd_pipe_reg[PIPE_D-1];
        if (soft_next < eb_lo)
        begin
            soft_next = eb_lo;
        end
        if (soft_next > eb_hi)
        begin
            soft_next = eb_hi;
        end

        hard_lo = lo_zero_pipe_reg[PIPE_D-1] ? '0 : -emax;
        hard_hi = hi_zero_pipe_reg[PIPE_D-1] ? '0 : emax;
        hard_next = cmd_pipe_reg[PIPE_D-1];
        if (hard_next < hard_lo)
        begin
            hard_next = hard_lo;
        end
        if (hard_next > hard_hi)
        begin
            hard_next = hard_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eb_valid)
        begin
            soft_reg <= soft_next;
            hard_reg <= hard_next;
        end
    end

    assign done                = done_reg;
    assign soft_limited_effort = soft_reg;
    assign hard_limited_effort = hard_reg;

    `JESHL_ASSERT_NEXT(a_done_follows, clk, rst_n, eb_valid, done_reg)
    `JESHL_ASSERT_SAME(a_hard_range, clk, rst_n, done_reg,
        (hard_reg <= emax) && (hard_reg >= -emax))
    `JESHL_ASSERT_NEXT(a_soft_upper, clk, rst_n, eb_valid,
        soft_reg <= $past(eb_hi))
    `JESHL_ASSERT_SAME(a_lanes_aligned, clk, rst_n, vb_valid || eb_valid,
        (vb_valid == vb_hi_valid_unused) && (eb_valid == eb_lo_valid_unused))
endmodule

/* hdl/jeshl_scale_clamp.sv */
// ----------------------------------------------------------------------------
// jeshl scale and clamp
// two stage sign-magnitude gain multiply, truncate, saturate to +-limit
// ----------------------------------------------------------------------------
`include "joint_effort_soft_hard_limiter_core_defines.svh"

module jeshl_scale_clamp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_neg,
    input  jeshl_pkg::mag_t  in_mag,
    input  jeshl_pkg::ufix_t gain,
    input  jeshl_pkg::ufix_t limit,
    output logic            out_valid,
    output jeshl_pkg::sfix_t bound
);
    import jeshl_pkg::*;

    logic        prod_valid_reg;
    logic        out_valid_reg;
    logic        neg_reg;
    prod_t       prod_reg;
    prod_t       prod_next;
    sfix_t       bound_reg;
    sfix_t       bound_next;
    logic [47:0] quot;
    logic [31:0] mag_sat;
    logic        over;

    assign prod_next = PROD_W'(in_mag) * PROD_W'(gain);
    assign quot      = prod_reg[PROD_W-1:FRAC_W];
    assign over      = quot > {17'b0, limit};
    assign mag_sat   = over ? {1'b0, limit} : quot[31:0];

    always_comb
    begin
        if (neg_reg)
        begin
            bound_next = sfix_t'(-mag_sat);
        end
        else
        begin
            bound_next = sfix_t'(mag_sat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= prod_next;
            neg_reg  <= in_neg;
        end
        if (prod_valid_reg)
        begin
            bound_reg <= bound_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign bound     = bound_reg;

    `JESHL_ASSERT_NEXT(a_valid_chain, clk, rst_n, prod_valid_reg, out_valid_reg)
    `JESHL_ASSERT_SAME(a_bound_range, clk, rst_n, out_valid_reg,
        (bound_reg <= $signed({1'b0, limit})) && (bound_reg >= -$signed({1'b0, limit})))
    `JESHL_ASSERT_NEXT(a_bound_sign, clk, rst_n, prod_valid_reg && !neg_reg,
        !bound_reg[31])
endmodule
